@@ rtl/core/gpiobt_pkg.sv @@
// Package with constants, command codes and error codes of the GPIO bank with loopback and trace.
`default_nettype none

package gpiobt_pkg;

  localparam int NumPins    = 32;
  localparam int TraceDepth = 4096;
  localparam int PatW       = 32;

  localparam int PinW      = (NumPins > 1) ? $clog2(NumPins) : 1;
  localparam int TraceAw   = (TraceDepth > 1) ? $clog2(TraceDepth) : 1;
  localparam int TraceCntW = $clog2(TraceDepth + 1);
  localparam int StimLenW  = $clog2(PatW + 1);
  localparam int PatIdxW   = $clog2(PatW);

  // Field widths of one transfer.
  localparam int CmdW   = 3;
  localparam int PinFW  = 6;
  localparam int SrcW   = 7;
  localparam int NbitsW = 8;
  localparam int IndexW = 13;
  localparam int CountW = 13;
  localparam int EntryW = 6;
  localparam int ErrW   = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_MODE        = 3'd0,
    CMD_WRITE       = 3'd1,
    CMD_READ        = 3'd2,
    CMD_FEED        = 3'd3,
    CMD_WIRE        = 3'd4,
    CMD_TRACE_CLEAR = 3'd5,
    CMD_TRACE_LEN   = 3'd6,
    CMD_TRACE_GET   = 3'd7
  } cmd_e;

  typedef enum logic [ErrW-1:0] {
    ERR_OK        = 2'd0,
    ERR_PIN_RANGE = 2'd1,
    ERR_NOT_OUT   = 2'd2,
    ERR_TRACE_IDX = 2'd3
  } err_e;

endpackage

`default_nettype wire

@@ rtl/core/gpio_bank_with_loopback_and_trace.sv @@
// Top level of the GPIO bank with pin loopback, serial stimulus and a write trace.
`default_nettype none

// Usage:
// A command transfer is taken at a rising edge of clk_i where start_i is high
// and busy_o is low. The bank never stalls, so busy_o stays low and a new
// command may be issued in every cycle.
// Each command produces exactly one result, shown on the result ports for one
// cycle with done_o high, in the cycle right after the command was taken
// (throughput one command per cycle). All pin state, the
// stimulus counters and the trace fill are updated at the edge that takes the
// command; the trace store is written at that edge and read there too, its
// read data landing in the result register, so a trace get right after a
// write already sees the new entry.
// The receiver has no way to hold results off; a result not taken in its
// cycle is lost.
// Reset makes every pin an input, clears the latches, wiring, stimulus and the
// trace fill. The trace store itself is not cleared: only entries below the
// fill count are ever read back, and those have been written.
module gpio_bank_with_loopback_and_trace (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [gpiobt_pkg::CmdW-1:0]      cmd_i,
  input  logic [gpiobt_pkg::PinFW-1:0]     pin_i,
  input  logic                             value_i,
  input  logic signed [gpiobt_pkg::SrcW-1:0] source_i,
  input  logic [gpiobt_pkg::PatW-1:0]      pattern_i,
  input  logic [gpiobt_pkg::NbitsW-1:0]    nbits_i,
  input  logic [gpiobt_pkg::IndexW-1:0]    index_i,
  output logic                             done_o,
  output logic                             read_bit_o,
  output logic [gpiobt_pkg::CountW-1:0]    trace_count_o,
  output logic [gpiobt_pkg::EntryW-1:0]    trace_entry_o,
  output logic [gpiobt_pkg::ErrW-1:0]      error_o
);
  import gpiobt_pkg::*;

  // Pin state.
  logic [NumPins-1:0]  dir_q, dir_d;
  logic [NumPins-1:0]  latch_q, latch_d;
  logic [NumPins-1:0]  wire_vld_q, wire_vld_d;
  logic [PinW-1:0]     wire_src_q [NumPins];
  logic [PinW-1:0]     wire_src_d [NumPins];
  logic [PatW-1:0]     stim_pat_q [NumPins];
  logic [PatW-1:0]     stim_pat_d [NumPins];
  logic [StimLenW-1:0] stim_len_q [NumPins];
  logic [StimLenW-1:0] stim_len_d [NumPins];
  logic [StimLenW-1:0] stim_pos_q [NumPins];
  logic [StimLenW-1:0] stim_pos_d [NumPins];
  logic [TraceCntW-1:0] fill_q, fill_d;

  // Trace store.
  logic [EntryW-1:0]  trace_mem [TraceDepth];
  logic               mem_we;
  logic [TraceAw-1:0] mem_waddr;
  logic [EntryW-1:0]  mem_wdata;
  logic               mem_re;
  logic [TraceAw-1:0] mem_raddr;
  logic [EntryW-1:0]  rdata_q;

  // Result registers.
  logic              done_q;
  logic              read_bit_q, read_bit_d;
  logic [CountW-1:0] count_q, count_d;
  logic              get_ok_q, get_ok_d;
  err_e              err_q, err_d;

  // Decode helpers.
  cmd_e                cmd;
  logic                accept;
  logic                pin_ok;
  logic [PinW-1:0]     pidx;
  logic                src_ok;
  logic [StimLenW-1:0] nbits_sat;
  logic [StimLenW-1:0] cur_len;
  logic [StimLenW-1:0] cur_pos;
  logic [StimLenW-1:0] bit_sel;
  logic [IndexW-1:0]   index_m1;
  logic                index_ok;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign cmd    = cmd_e'(cmd_i);
  assign pin_ok = pin_i < PinFW'(NumPins);
  assign pidx   = pin_i[PinW-1:0];
  assign src_ok = !source_i[SrcW-1] && (source_i[SrcW-2:0] < (SrcW-1)'(NumPins));
  assign nbits_sat = (nbits_i > NbitsW'(PatW)) ? StimLenW'(PatW) : nbits_i[StimLenW-1:0];
  assign cur_len   = stim_len_q[pidx];
  assign index_m1  = index_i - IndexW'(1);
  assign index_ok  = (index_i != '0) && ({1'b0, index_i} <= (IndexW + 1)'(fill_q));

  always_comb begin
    dir_d      = dir_q;
    latch_d    = latch_q;
    wire_vld_d = wire_vld_q;
    wire_src_d = wire_src_q;
    stim_pat_d = stim_pat_q;
    stim_len_d = stim_len_q;
    stim_pos_d = stim_pos_q;
    fill_d     = fill_q;
    mem_we     = 1'b0;
    mem_waddr  = fill_q[TraceAw-1:0];
    mem_wdata  = EntryW'({pidx, value_i});
    mem_re     = 1'b0;
    mem_raddr  = index_m1[TraceAw-1:0];
    read_bit_d = 1'b0;
    count_d    = '0;
    get_ok_d   = 1'b0;
    err_d      = ERR_OK;
    cur_pos    = stim_pos_q[pidx];
    bit_sel    = '0;

    if (accept) begin
      unique case (cmd)
        CMD_MODE: begin
          if (!pin_ok) begin
            err_d = ERR_PIN_RANGE;
          end else begin
            dir_d[pidx] = value_i;
          end
        end
        CMD_WRITE: begin
          if (!pin_ok) begin
            err_d = ERR_PIN_RANGE;
          end else if (!dir_q[pidx]) begin
            err_d = ERR_NOT_OUT;
          end else begin
            latch_d[pidx] = value_i;
            if (fill_q < TraceCntW'(TraceDepth)) begin
              mem_we = 1'b1;
              fill_d = fill_q + TraceCntW'(1);
            end
          end
        end
        CMD_READ: begin
          if (!pin_ok) begin
            err_d = ERR_PIN_RANGE;
          end else if (dir_q[pidx]) begin
            read_bit_d = latch_q[pidx];
          end else if (cur_len != '0) begin
            // Step through the pattern, then keep returning its last bit.
            if (cur_pos < cur_len) begin
              stim_pos_d[pidx] = cur_pos + StimLenW'(1);
            end else begin
              cur_pos = cur_len - StimLenW'(1);
            end
            bit_sel    = cur_len - StimLenW'(1) - cur_pos;
            read_bit_d = stim_pat_q[pidx][bit_sel[PatIdxW-1:0]];
          end else if (wire_vld_q[pidx]) begin
            read_bit_d = latch_q[wire_src_q[pidx]];
          end
        end
        CMD_FEED: begin
          if (!pin_ok) begin
            err_d = ERR_PIN_RANGE;
          end else begin
            stim_pat_d[pidx] = pattern_i;
            stim_len_d[pidx] = nbits_sat;
            stim_pos_d[pidx] = '0;
          end
        end
        CMD_WIRE: begin
          if (!pin_ok) begin
            err_d = ERR_PIN_RANGE;
          end else if (src_ok) begin
            wire_vld_d[pidx] = 1'b1;
            wire_src_d[pidx] = source_i[PinW-1:0];
          end else begin
            wire_vld_d[pidx] = 1'b0;
            wire_src_d[pidx] = '0;
          end
        end
        CMD_TRACE_CLEAR: begin
          fill_d = '0;
        end
        CMD_TRACE_LEN: begin
          count_d = CountW'(fill_q);
        end
        CMD_TRACE_GET: begin
          if (!index_ok) begin
            err_d = ERR_TRACE_IDX;
          end else begin
            mem_re   = 1'b1;
            get_ok_d = 1'b1;
          end
        end
        default: begin
          err_d = ERR_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= '0;
      latch_q    <= '0;
      wire_vld_q <= '0;
      for (int i = 0; i < NumPins; i++) begin
        wire_src_q[i] <= '0;
        stim_pat_q[i] <= '0;
        stim_len_q[i] <= '0;
        stim_pos_q[i] <= '0;
      end
      fill_q     <= '0;
      done_q     <= 1'b0;
      read_bit_q <= 1'b0;
      count_q    <= '0;
      get_ok_q   <= 1'b0;
      err_q      <= ERR_OK;
    end else begin
      dir_q      <= dir_d;
      latch_q    <= latch_d;
      wire_vld_q <= wire_vld_d;
      wire_src_q <= wire_src_d;
      stim_pat_q <= stim_pat_d;
      stim_len_q <= stim_len_d;
      stim_pos_q <= stim_pos_d;
      fill_q     <= fill_d;
      done_q     <= accept;
      read_bit_q <= read_bit_d;
      count_q    <= count_d;
      get_ok_q   <= get_ok_d;
      err_q      <= err_d;
    end
  end

  // Trace store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      trace_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= trace_mem[mem_raddr];
    end
  end

  assign done_o        = done_q;
  assign read_bit_o    = read_bit_q;
  assign trace_count_o = count_q;
  assign trace_entry_o = get_ok_q ? rdata_q : '0;
  assign error_o       = err_q;

endmodule

`default_nettype wire
